// ===== hw/rtl/qpht_pkg.sv =====
// shared constants for the quadratic probing hash table
// field widths, register index, operation codes; no dependencies
package qpht_pkg;

  localparam int unsigned SIZE_W     = 15;   // table_size register width
  localparam int unsigned PROBE_W    = 15;   // probes result field width
  localparam int unsigned KEY_IN_W   = 20;   // key input field width
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 15'd11;

  // register index taken from the word address
  localparam logic REG_TABLE_SIZE = 1'b0;

  // operation codes on the input selector
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
// quadratic probing hash table: insert and search over a slot memory
// depends on qpht_pkg
//
// usage
//   input stream: s_tvalid/s_tready, s_tuser = operation (insert or search),
//   s_tdata = key. result stream: m_tvalid/m_tready, m_tuser = ok flag,
//   m_tdata = number of slots examined. one result per input transaction.
//   apb port: register table_size at byte address 0 (write while idle)
//   operation: one transaction at a time. after acceptance the home slot
//   (key mod size) is found by a bit-serial remainder, then every probe
//   takes a memory read state, then a compare and advance state; the
//   single add/reduce unit and the slot memory's one read port keep
//   these steps serial
//   reset: table_size returns to 11 and a clearing pass walks the slot
//   memory, one entry per cycle, every entry once; s_tready stays low
//   during the pass, apb writes are still taken
//   stall: a result waits in the output register while m_tready is low;
//   the next input transaction is still taken, and its walk holds at the
//   final probe until the output register is free
module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16384,
  parameter int unsigned KEY_BITS    = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // input transactions
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // [19:0] key, [23:20] zero fill
  input  logic                  s_tuser,   // [0] op
  // result transactions
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [14:0] probes, [15] zero fill
  output logic                  m_tuser,   // [0] ok
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned SW  = $clog2(TABLE_DEPTH + 1);     // effective size
  localparam int unsigned PW  = $clog2(TABLE_DEPTH + 2);     // probe counter
  localparam int unsigned BCW = $clog2(KEY_BITS + 1);        // remainder steps
  localparam int unsigned EW  = KEY_BITS + 1;                // used bit + key

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_EVAL = 3'd4;

  logic [2:0]          state;
  logic [SIZE_W-1:0]   table_size;
  logic [AW-1:0]       clr_addr;

  // per-item work registers
  logic                op;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] key_sh;     // key bits fed msb first to the remainder
  logic [BCW-1:0]      bit_cnt;
  logic [SW-1:0]       size;
  logic                size_one;
  logic [SW-1:0]       slot;       // remainder while dividing, then probe slot
  logic [SW-1:0]       step;       // (2j+1) mod size
  logic [PW-1:0]       cnt;        // number of the current probe, from 1

  // slot memory: {used, key}
  logic [EW-1:0]       mem [TABLE_DEPTH];
  logic [EW-1:0]       rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;

  // output register
  logic                out_ok;
  logic [PW-1:0]       out_probes;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_wr && paddr[2] == REG_TABLE_SIZE) begin
      table_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TABLE_SIZE) ?
                  {{(CFG_DATA_W-SIZE_W){1'b0}}, table_size} : '0;

  // effective size: zero acts as one, above the depth acts as the depth
  logic [SW-1:0] size_eff;
  always_comb begin
    if (table_size == '0) begin
      size_eff = SW'(1);
    end else if (32'(table_size) > TABLE_DEPTH) begin
      size_eff = SW'(TABLE_DEPTH);
    end else begin
      size_eff = SW'(table_size);
    end
  end

  // ---------------------------------------------------------------------
  // shared add and reduce unit: (a + b + cin) mod size for a, b < size
  // ---------------------------------------------------------------------
  logic [SW-1:0] u_a, u_b, u_res;
  logic          u_cin;
  logic [SW:0]   u_sum, u_diff;

  always_comb begin
    case (state)
      ST_DIV: begin
        u_a   = slot;
        u_b   = slot;
        u_cin = key_sh[KEY_BITS-1];
      end
      ST_RD: begin
        u_a   = step;
        u_b   = SW'(1);
        u_cin = 1'b1;
      end
      default: begin
        u_a   = slot;
        u_b   = step;
        u_cin = 1'b0;
      end
    endcase
  end

  always_comb begin
    u_sum  = {1'b0, u_a} + {1'b0, u_b} + {{SW{1'b0}}, u_cin};
    u_diff = u_sum - {1'b0, size};
    if (size_one) begin
      u_res = '0;                       // every value is zero mod one
    end else if (u_sum >= {1'b0, size}) begin
      u_res = u_diff[SW-1:0];
    end else begin
      u_res = u_sum[SW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // probe evaluation
  // ---------------------------------------------------------------------
  logic slot_used_rd, key_hit, done, last_probe;
  assign slot_used_rd = rd_data[EW-1];
  assign key_hit      = slot_used_rd && (rd_data[KEY_BITS-1:0] == key);
  assign last_probe   = (cnt == PW'({1'b0, size} + 1'b1));
  assign done         = (op == OP_INSERT) ? !slot_used_rd : (!slot_used_rd || key_hit);

  // the walk ends only when the output register is free or being emptied
  logic in_acc, out_free, finish;
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_EVAL) && (done || last_probe) && out_free;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (bit_cnt == BCW'(KEY_BITS - 1)) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (finish) begin
            state <= ST_IDLE;
          end else if (!done && !last_probe) begin
            state <= ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          op       <= s_tuser;
          key      <= KEY_BITS'(s_tdata[KEY_IN_W-1:0]);
          key_sh   <= KEY_BITS'(s_tdata[KEY_IN_W-1:0]);
          size     <= size_eff;
          size_one <= (size_eff == SW'(1));
          slot     <= '0;
          bit_cnt  <= '0;
        end
      end
      ST_DIV: begin
        slot    <= u_res;
        key_sh  <= key_sh << 1;
        bit_cnt <= bit_cnt + 1'b1;
        // minus one mod size, so the first read state lifts it to one
        step    <= size - SW'(1);
        cnt     <= PW'(1);
      end
      ST_RD: begin
        // step update for the following probe; slot stays for this one
        step <= u_res;
      end
      ST_EVAL: begin
        if (finish) begin
          out_ok     <= done && (op == OP_INSERT || key_hit);
          out_probes <= cnt;
        end else if (!done && !last_probe) begin
          slot <= u_res;
          cnt  <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // slot memory, one write and one registered read per cycle
  // ---------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot[AW-1:0];
    wr_data = {1'b1, key};
    if (state == ST_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (finish && op == OP_INSERT && !slot_used_rd) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[slot[AW-1:0]];
  end

  assign m_tuser = out_ok;
  assign m_tdata = {1'b0, PROBE_W'(out_probes)};

endmodule
